// ===== rtl/integer_to_radix_digits_core_macros.svh =====
// ---------------------------------------------------------------------------
// Assertion macros for the radix conversion core
// Concurrent assertion shorthands with clock and asynchronous reset.
// ---------------------------------------------------------------------------
`ifndef INTEGER_TO_RADIX_DIGITS_CORE_MACROS_SVH
`define INTEGER_TO_RADIX_DIGITS_CORE_MACROS_SVH

// Same-cycle implication, disabled while reset is asserted.
`define ITRD_ASSERT_NOW(lbl, clk, rst_n, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error(msg);

// Next-cycle implication, disabled while reset is asserted.
`define ITRD_ASSERT_NEXT(lbl, clk, rst_n, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

// ===== rtl/itrd_pkg.sv =====
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// itrd_pkg
// Shared constants, types and the alphabet lookup for the radix converter.
// ---------------------------------------------------------------------------
package itrd_pkg;

	localparam int MAX_RADIX_DEF   = 16;
	localparam int VALUE_BITS_DEF  = 32;
	localparam int STACK_DEPTH_DEF = 32;

	localparam int RADIX_W       = 5;
	localparam int DIGIT_W       = 4;
	localparam int CHAR_W        = 8;
	localparam int ALPHA_SIZE    = 16;
	localparam int DIV_STEP_BITS = 8;

	localparam int CFG_IDX_W  = 2;
	localparam int CFG_DATA_W = 64;

	localparam logic [CFG_IDX_W-1:0] REG_BASE_SIZE = 2'd0;
	localparam logic [CFG_IDX_W-1:0] REG_CHARS_LOW  = 2'd1;
	localparam logic [CFG_IDX_W-1:0] REG_CHARS_HIGH = 2'd2;

	localparam logic [RADIX_W-1:0]    BASE_SIZE_RST  = 5'd10;
	localparam logic [CFG_DATA_W-1:0] CHARS_LOW_RST  = 64'h3736_3534_3332_3130;
	localparam logic [CFG_DATA_W-1:0] CHARS_HIGH_RST = 64'h6665_6463_6261_3938;
	localparam logic [RADIX_W-1:0]    RADIX_MIN      = 5'd2;

	localparam logic [CHAR_W-1:0] CHAR_PLUS  = 8'h2B;
	localparam logic [CHAR_W-1:0] CHAR_MINUS = 8'h2D;

	typedef struct packed {
		logic               start;
		logic [RADIX_W-1:0] radix;
	} div_ctrl_t;

	typedef struct packed {
		logic               done;
		logic [DIGIT_W-1:0] digit;
	} div_stat_t;

	// Character k of the sixteen-entry alphabet held in two 64-bit words.
	function automatic logic [CHAR_W-1:0] alphabet_char(
		input logic [CFG_DATA_W-1:0] lo,
		input logic [CFG_DATA_W-1:0] hi,
		input logic [DIGIT_W-1:0]    k
	);
		logic [CFG_DATA_W-1:0] word;
		word = k[3] ? hi : lo;
		return word[{k[2:0], 3'b000} +: CHAR_W];
	endfunction

endpackage

// ===== rtl/itrd_if.sv =====
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// itrd_if
// Valid/ready channels for the integer input and the character output.
// ---------------------------------------------------------------------------
interface itrd_in_if #(
	parameter int VALUE_BITS = itrd_pkg::VALUE_BITS_DEF
);
	logic                  valid;
	logic                  ready;
	logic [VALUE_BITS-1:0] value;

	modport source (output valid, output value, input ready);
	modport sink   (input valid, input value, output ready);
endinterface

interface itrd_out_if;
	logic                        valid;
	logic                        ready;
	logic [itrd_pkg::CHAR_W-1:0] character;
	logic                        last;

	modport source (output valid, output character, output last, input ready);
	modport sink   (input valid, input character, input last, output ready);
endinterface

// ===== rtl/itrd_div.sv =====
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// itrd_div
// Iterative divider by a small radix, eight quotient bits per cycle.
// ---------------------------------------------------------------------------
module itrd_div #(
	parameter int VALUE_BITS = itrd_pkg::VALUE_BITS_DEF
) (
	input  logic                  clk,
	input  logic                  arst_n,
	input  itrd_pkg::div_ctrl_t   ctrl,
	input  logic [VALUE_BITS-1:0] dividend,
	output itrd_pkg::div_stat_t   stat,
	output logic [VALUE_BITS-1:0] quotient
);

	localparam int STEP   = itrd_pkg::DIV_STEP_BITS;
	localparam int CHUNKS = (VALUE_BITS + STEP - 1) / STEP;
	localparam int PAD    = CHUNKS * STEP;
	localparam int CNT_W  = $clog2(CHUNKS + 1);

	logic [PAD-1:0]                   work_q;
	logic [itrd_pkg::DIGIT_W-1:0]     part_q;
	logic [itrd_pkg::RADIX_W-1:0]     radix_q;
	logic [CNT_W-1:0]                 cnt_q;
	logic                             done_q;
	logic [STEP-1:0]                  qbits;
	logic [itrd_pkg::DIGIT_W-1:0]     part_nx;

	// Restoring division over the top byte of the working register.
	always_comb begin
		logic [itrd_pkg::RADIX_W-1:0] r;
		logic [itrd_pkg::DIGIT_W-1:0] p;
		p = part_q;
		qbits = '0;
		for (int i = 0; i < STEP; i++) begin
			r = {p, work_q[PAD-1-i]};
			if (r >= radix_q) begin
				qbits[STEP-1-i] = 1'b1;
				r = r - radix_q;
			end
			p = r[itrd_pkg::DIGIT_W-1:0];
		end
		part_nx = p;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q   <= '0;
			done_q  <= 1'b0;
			work_q  <= '0;
			part_q  <= '0;
			radix_q <= '0;
		end else if (ctrl.start) begin
			cnt_q   <= CNT_W'(CHUNKS);
			done_q  <= 1'b0;
			work_q  <= PAD'(dividend);
			part_q  <= '0;
			radix_q <= ctrl.radix;
		end else if (cnt_q != '0) begin
			cnt_q  <= cnt_q - CNT_W'(1);
			done_q <= (cnt_q == CNT_W'(1));
			work_q <= (work_q << STEP) | PAD'(qbits);
			part_q <= part_nx;
		end else begin
			done_q <= 1'b0;
		end
	end

	assign stat.done  = done_q;
	assign stat.digit = part_q;
	assign quotient   = work_q[VALUE_BITS-1:0];

endmodule

// ===== rtl/integer_to_radix_digits_core.sv =====
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// integer_to_radix_digits_core
// Converts signed integers into digit characters of a configurable radix.
// ---------------------------------------------------------------------------
//
//  Channel  Direction  Payload              Item
//  values   in         value [VALUE_BITS]   one signed integer
//  chars    out        character [8], last  one character, sign or digit
//  cfg_*    in         index [2], data [64] one register write, no read-back
//
// Operation: the shared divider yields eight quotient bits a cycle, one digit per
// division, then characters leave one per cycle while the output is not stalled.
// Reset: arst_n clears the sequencer and restores the default radix and alphabet.
// Stalls: a stalled output holds its item and halts emission; the input is ready
// again once at most the final character waits in the output register.
// ---------------------------------------------------------------------------
module integer_to_radix_digits_core #(
	parameter int MAX_RADIX   = itrd_pkg::MAX_RADIX_DEF,
	parameter int VALUE_BITS  = itrd_pkg::VALUE_BITS_DEF,
	parameter int STACK_DEPTH = itrd_pkg::STACK_DEPTH_DEF
) (
	input  logic                           clk,
	input  logic                           arst_n,
	input  logic                           cfg_we,
	input  logic [itrd_pkg::CFG_IDX_W-1:0]  cfg_index,
	input  logic [itrd_pkg::CFG_DATA_W-1:0] cfg_data,
	itrd_in_if.sink                        values,
	itrd_out_if.source                     chars
);

	localparam int AW = $clog2(STACK_DEPTH);
	localparam int CW = $clog2(STACK_DEPTH + 1);
	localparam logic [itrd_pkg::RADIX_W-1:0] RADIX_MAX = itrd_pkg::RADIX_W'(MAX_RADIX);

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_DIVIDE,
		ST_EMIT
	} state_t;

	// Configuration registers.
	logic [itrd_pkg::RADIX_W-1:0]    base_q;
	logic [itrd_pkg::CFG_DATA_W-1:0] low_q;
	logic [itrd_pkg::CFG_DATA_W-1:0] high_q;

	// Sequencer state.
	state_t                          state_q;
	logic                            neg_q;
	logic [CW-1:0]                   count_q;
	logic [CW-1:0]                   idx_q;
	logic                            sgn_q;

	// Read stage behind the digit stack, then the output register.
	logic                            rdv_q;
	logic                            rds_q;
	logic                            rdl_q;
	logic [itrd_pkg::DIGIT_W-1:0]    rd_q;
	logic                            ov_q;
	logic [itrd_pkg::CHAR_W-1:0]     oc_q;
	logic                            ol_q;

	logic [itrd_pkg::DIGIT_W-1:0]    stack_mem [STACK_DEPTH];

	logic [itrd_pkg::RADIX_W-1:0]    radix_sat;
	logic                            alpha_bad;
	logic                            in_neg;
	logic [VALUE_BITS-1:0]           in_mag;
	logic                            start_ok;
	logic                            move_b;
	logic                            issue;
	logic                            wr_en;
	logic [AW-1:0]                   rd_addr;
	itrd_pkg::div_ctrl_t             div_ctrl;
	itrd_pkg::div_stat_t             div_stat;
	logic [VALUE_BITS-1:0]           div_dividend;
	logic [VALUE_BITS-1:0]           div_quot;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			base_q <= itrd_pkg::BASE_SIZE_RST;
			low_q  <= itrd_pkg::CHARS_LOW_RST;
			high_q <= itrd_pkg::CHARS_HIGH_RST;
		end else if (cfg_we) begin
			case (cfg_index)
				itrd_pkg::REG_BASE_SIZE:  base_q <= cfg_data[itrd_pkg::RADIX_W-1:0];
				itrd_pkg::REG_CHARS_LOW:  low_q  <= cfg_data;
				itrd_pkg::REG_CHARS_HIGH: high_q <= cfg_data;
				default: ;
			endcase
		end
	end

	// The radix saturates at the largest supported value. A number is only
	// converted when the radix is at least two and none of the alphabet
	// characters in use is a plus or minus sign.
	always_comb begin
		logic [itrd_pkg::CHAR_W-1:0] c;
		radix_sat = (base_q > RADIX_MAX) ? RADIX_MAX : base_q;
		alpha_bad = 1'b0;
		for (int k = 0; k < itrd_pkg::ALPHA_SIZE; k++) begin
			c = itrd_pkg::alphabet_char(low_q, high_q, itrd_pkg::DIGIT_W'(k));
			if ((itrd_pkg::RADIX_W'(k) < radix_sat) &&
			    ((c == itrd_pkg::CHAR_PLUS) || (c == itrd_pkg::CHAR_MINUS))) begin
				alpha_bad = 1'b1;
			end
		end
	end

	// The magnitude fits the value width unsigned, the most negative value
	// included, so a plain two's complement negation suffices.
	assign in_neg   = values.value[VALUE_BITS-1];
	assign in_mag   = in_neg ? (~values.value + VALUE_BITS'(1)) : values.value;
	assign start_ok = values.valid && values.ready &&
	                  (radix_sat >= itrd_pkg::RADIX_MIN) && !alpha_bad;

	// The divider is restarted on its own quotient until that reaches zero.
	assign div_dividend   = (state_q == ST_IDLE) ? in_mag : div_quot;
	assign div_ctrl.radix = radix_sat;
	assign div_ctrl.start = start_ok ||
	                        ((state_q == ST_DIVIDE) && div_stat.done && (div_quot != '0));

	itrd_div #(
		.VALUE_BITS (VALUE_BITS)
	) u_div (
		.clk      (clk),
		.arst_n   (arst_n),
		.ctrl     (div_ctrl),
		.dividend (div_dividend),
		.stat     (div_stat),
		.quotient (div_quot)
	);

	// Digits beyond the stack depth are computed but dropped, so only the
	// least significant ones are kept.
	assign wr_en = (state_q == ST_DIVIDE) && div_stat.done && (count_q < CW'(STACK_DEPTH));

	// Emission walks the stack from the top, the sign going first when the
	// number is negative. The read stage refills whenever it hands its item on.
	assign move_b  = rdv_q && (!ov_q || chars.ready);
	assign issue   = (state_q == ST_EMIT) && (sgn_q || (idx_q != '0)) && (!rdv_q || move_b);
	assign rd_addr = AW'(idx_q - CW'(1));

	always_ff @(posedge clk) begin
		if (wr_en) begin
			stack_mem[count_q[AW-1:0]] <= div_stat.digit;
		end
	end

	always_ff @(posedge clk) begin
		if (issue && !sgn_q) begin
			rd_q <= stack_mem[rd_addr];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			neg_q   <= 1'b0;
			count_q <= '0;
			idx_q   <= '0;
			sgn_q   <= 1'b0;
			rdv_q   <= 1'b0;
			rds_q   <= 1'b0;
			rdl_q   <= 1'b0;
			ov_q    <= 1'b0;
			oc_q    <= '0;
			ol_q    <= 1'b0;
		end else begin
			if (move_b) begin
				ov_q  <= 1'b1;
				oc_q  <= rds_q ? itrd_pkg::CHAR_MINUS
				               : itrd_pkg::alphabet_char(low_q, high_q, rd_q);
				ol_q  <= rdl_q;
			end else if (chars.ready) begin
				ov_q <= 1'b0;
			end
			if (issue) begin
				rdv_q <= 1'b1;
				rds_q <= sgn_q;
				rdl_q <= !sgn_q && (idx_q == CW'(1));
				if (sgn_q) begin
					sgn_q <= 1'b0;
				end else begin
					idx_q <= idx_q - CW'(1);
				end
			end else if (move_b) begin
				rdv_q <= 1'b0;
			end

			case (state_q)
				ST_IDLE: begin
					if (start_ok) begin
						neg_q   <= in_neg;
						count_q <= '0;
						state_q <= ST_DIVIDE;
					end
				end
				ST_DIVIDE: begin
					if (div_stat.done) begin
						if (wr_en) begin
							count_q <= count_q + CW'(1);
						end
						if (div_quot == '0) begin
							idx_q   <= wr_en ? (count_q + CW'(1)) : count_q;
							sgn_q   <= neg_q;
							state_q <= ST_EMIT;
						end
					end
				end
				ST_EMIT: begin
					if ((idx_q == '0) && !sgn_q && (!rdv_q || move_b)) begin
						state_q <= ST_IDLE;
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	assign values.ready    = (state_q == ST_IDLE);
	assign chars.valid     = ov_q;
	assign chars.character = oc_q;
	assign chars.last      = ol_q;

endmodule

// ===== rtl/itrd_chk.sv =====
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// itrd_chk
// Port-level checks of the radix converter, bound to the top level.
// ---------------------------------------------------------------------------
`include "integer_to_radix_digits_core_macros.svh"

module itrd_chk (
	input logic                        clk,
	input logic                        arst_n,
	input logic                        in_ready,
	input logic                        out_valid,
	input logic                        out_ready,
	input logic [itrd_pkg::CHAR_W-1:0] out_character,
	input logic                        out_last
);

	`ITRD_ASSERT_NEXT(a_out_hold, clk, arst_n, out_valid && !out_ready, out_valid, "output item dropped while stalled")

	`ITRD_ASSERT_NEXT(a_out_stable, clk, arst_n, out_valid && !out_ready, $stable(out_character) && $stable(out_last), "stalled output item changed")

	// While a new number may enter, only the previous number's final
	// character can still be waiting.
	`ITRD_ASSERT_NOW(a_idle_last, clk, arst_n, in_ready && out_valid, out_last, "input ready with a number still in flight")

	// Characters of one number follow without gaps once they have started.
	`ITRD_ASSERT_NEXT(a_no_gap, clk, arst_n, out_valid && out_ready && !out_last, out_valid, "gap inside a number")

endmodule

bind integer_to_radix_digits_core itrd_chk u_itrd_chk (
	.clk           (clk),
	.arst_n        (arst_n),
	.in_ready      (values.ready),
	.out_valid     (chars.valid),
	.out_ready     (chars.ready),
	.out_character (chars.character),
	.out_last      (chars.last)
);

// ===== bench/tb_integer_to_radix_digits_core.sv =====
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// tb_integer_to_radix_digits_core
// Self-checking bench for the signed integer to radix character converter.
// Numbers are pushed through the valid/ready input channel. A predictor
// works out the characters that each accepted number should yield under the
// radix and alphabet currently programmed. The character stream is checked
// item by item against those characters. The run covers a directed set of
// corner values and register settings, then random numbers under a series
// of random radices and alphabets, with random idling on both channels.
// ---------------------------------------------------------------------------
module tb_integer_to_radix_digits_core;

	localparam int RESET_CYCLES = 9;
	// Long enough for radix 2 on the most negative value, so this covers a
	// number that is still being converted when the last expected character
	// has left, or one that is being thrown away.
	localparam int DRAIN_CYCLES = 250;
	localparam int CYCLE_LIMIT  = 1_000_000;
	localparam int LONG_HOLD    = 400;
	localparam int PHASE_ITEMS  = 30;
	localparam int RANDOM_PHASES = 13;

	// The register map has three entries; the fourth index must be ignored.
	localparam logic [itrd_pkg::CFG_IDX_W-1:0] REG_UNUSED = 2'd3;

	localparam logic [31:0] DIRECTED_NUMBERS [13] = '{
		32'd0, 32'd1, 32'hFFFF_FFFF, 32'h7FFF_FFFF, 32'h8000_0000,
		32'd10, 32'hFFFF_FFF6, 32'd9, 32'h5555_5555, 32'hAAAA_AAAA,
		32'd99999, 32'hF8A4_32EB, 32'd1000000000
	};

	// One character of the output stream as the predictor expects it.
	typedef struct packed {
		logic [itrd_pkg::CHAR_W-1:0] character;
		logic                        last;
	} char_item_t;

	logic                            clk = 1'b0;
	logic                            arst_n;
	logic                            cfg_we;
	logic [itrd_pkg::CFG_IDX_W-1:0]  cfg_index;
	logic [itrd_pkg::CFG_DATA_W-1:0] cfg_data;

	itrd_in_if  values_if ();
	itrd_out_if chars_if ();

	integer_to_radix_digits_core dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.values    (values_if),
		.chars     (chars_if)
	);

	always #1 clk = ~clk;

	// The bench's own copy of the register contents, updated as each write
	// is issued. Writes only happen while the block is idle, so the copy is
	// always the setting under which the next accepted number is converted.
	logic [itrd_pkg::RADIX_W-1:0]    radix_setting;
	logic [itrd_pkg::CFG_DATA_W-1:0] glyphs_low;
	logic [itrd_pkg::CFG_DATA_W-1:0] glyphs_high;

	logic [31:0] numbers_to_send [$];
	char_item_t  chars_due [$];

	int    errors = 0;
	bit    bursts_on = 1'b0;
	bit    number_taken = 1'b0;
	int    send_gap = 0;
	int    ready_gap = 0;
	int    hold_left = 0;
	int    hold_requests = 0;
	int    holds_served = 0;
	longint cycles = 0;

	// Alphabet entry for one digit: entries 0 to 7 sit in the low word and
	// entries 8 to 15 in the high word, entry 0 in the bottom byte.
	function automatic logic [itrd_pkg::CHAR_W-1:0] glyph_at(
		logic [itrd_pkg::DIGIT_W-1:0] digit
	);
		logic [itrd_pkg::CFG_DATA_W-1:0] word;
		word = digit[3] ? glyphs_high : glyphs_low;
		return word[{digit[2:0], 3'b000} +: itrd_pkg::CHAR_W];
	endfunction

	// Appends to chars_due the characters that one number should produce.
	function automatic void expect_digits(logic [31:0] number);
		logic [itrd_pkg::RADIX_W-1:0] radix;
		logic [32:0]                  magnitude;
		logic [itrd_pkg::DIGIT_W-1:0] digits [32];
		int                           count;
		bit                           negative;
		// A radix above sixteen behaves as sixteen.
		radix = (radix_setting > 5'd16) ? 5'd16 : radix_setting;
		// Fewer than two digit characters: the number is dropped.
		if (radix < itrd_pkg::RADIX_MIN)
			return;
		// A sign character among the digits in use also drops the number.
		for (int k = 0; k < radix; k++) begin
			if (glyph_at(itrd_pkg::DIGIT_W'(k)) == itrd_pkg::CHAR_PLUS ||
			    glyph_at(itrd_pkg::DIGIT_W'(k)) == itrd_pkg::CHAR_MINUS)
				return;
		end
		negative = number[31];
		// One extra bit keeps the magnitude of the most negative value exact.
		magnitude = negative ? 33'd0 - {1'b1, number} : {1'b0, number};
		count = 0;
		do begin
			digits[count] = itrd_pkg::DIGIT_W'(magnitude % 33'(radix));
			count++;
			magnitude = magnitude / 33'(radix);
		end while (magnitude != 33'd0);
		if (negative)
			chars_due.push_back('{character: itrd_pkg::CHAR_MINUS, last: 1'b0});
		for (int k = count - 1; k >= 0; k--)
			chars_due.push_back('{character: glyph_at(digits[k]), last: 1'(k == 0)});
	endfunction

	// A spread of magnitudes: full range, small values around zero, values
	// of every length, and the extremes of the field.
	function automatic logic [31:0] random_number();
		logic [31:0] number;
		case ($urandom_range(0, 3))
			0: number = $urandom;
			1: number = 32'($urandom_range(0, 40)) - 32'd20;
			2: begin
				number = $urandom >> $urandom_range(0, 31);
				if ($urandom_range(0, 1) == 1)
					number = -number;
			end
			default: begin
				case ($urandom_range(0, 3))
					0: number = 32'h8000_0000;
					1: number = 32'h7FFF_FFFF;
					2: number = 32'h0000_0000;
					default: number = 32'hFFFF_FFFF;
				endcase
			end
		endcase
		return number;
	endfunction

	// One register write, one cycle wide, driven on falling edges.
	task automatic write_reg(logic [itrd_pkg::CFG_IDX_W-1:0] index,
	                         logic [itrd_pkg::CFG_DATA_W-1:0] data);
		@(negedge clk);
		cfg_we    <= 1'b1;
		cfg_index <= index;
		cfg_data  <= data;
		@(negedge clk);
		cfg_we <= 1'b0;
		case (index)
			itrd_pkg::REG_BASE_SIZE:  radix_setting = data[itrd_pkg::RADIX_W-1:0];
			itrd_pkg::REG_CHARS_LOW:  glyphs_low = data;
			itrd_pkg::REG_CHARS_HIGH: glyphs_high = data;
			default: ;
		endcase
	endtask

	// Returns once every queued number has been taken and every expected
	// character has arrived, then lets the block settle before the next
	// register write.
	task automatic wait_idle();
		while (numbers_to_send.size() != 0 || chars_due.size() != 0)
			@(negedge clk);
		repeat (DRAIN_CYCLES) @(negedge clk);
	endtask

	// Input side acceptance. The prediction is made at the edge at which a
	// number is taken, under the settings in force at that moment.
	always @(posedge clk) begin
		number_taken = arst_n && values_if.valid && values_if.ready;
		if (number_taken)
			expect_digits(values_if.value);
	end

	// Output side checking: each character is compared with the oldest
	// outstanding expectation, field by field.
	always @(posedge clk) begin : check_chars
		char_item_t due;
		if (arst_n && chars_if.valid && chars_if.ready) begin
			if (chars_due.size() == 0) begin
				errors++;
				$display("%0t: unexpected item: expected none, actual character %h last %b",
					$time, chars_if.character, chars_if.last);
			end else begin
				due = chars_due.pop_front();
				if (chars_if.character !== due.character) begin
					errors++;
					$display("%0t: character: expected %h, actual %h",
						$time, due.character, chars_if.character);
				end
				if (chars_if.last !== due.last) begin
					errors++;
					$display("%0t: last: expected %b, actual %b",
						$time, due.last, chars_if.last);
				end
			end
		end
	end

	// Number sender. Once raised, valid is held with the same number until
	// it is taken. Between numbers it may idle for a random burst while
	// bursts are enabled.
	always @(negedge clk) begin : drive_numbers
		logic        next_valid;
		logic [31:0] next_value;
		next_valid = values_if.valid;
		next_value = values_if.value;
		if (!arst_n) begin
			next_valid = 1'b0;
		end else begin
			if (number_taken) begin
				void'(numbers_to_send.pop_front());
				next_valid = 1'b0;
			end
			if (!next_valid && numbers_to_send.size() != 0) begin
				if (send_gap > 0) begin
					send_gap--;
				end else if (bursts_on && $urandom_range(0, 4) == 0) begin
					send_gap = $urandom_range(0, 2);
				end else begin
					next_valid = 1'b1;
					next_value = numbers_to_send[0];
				end
			end
		end
		values_if.valid <= next_valid;
		values_if.value <= next_value;
	end

	// Character receiver. It stalls in short random bursts, and on request
	// holds ready low for a long stretch so that the block fills up and has
	// to refuse further numbers.
	always @(negedge clk) begin : drive_ready
		logic next_ready;
		next_ready = 1'b0;
		if (arst_n) begin
			if (hold_requests != holds_served) begin
				holds_served = hold_requests;
				hold_left = LONG_HOLD;
			end
			if (hold_left > 0) begin
				hold_left--;
			end else if (ready_gap > 0) begin
				ready_gap--;
			end else if (bursts_on && $urandom_range(0, 4) == 0) begin
				ready_gap = $urandom_range(0, 2);
			end else begin
				next_ready = 1'b1;
			end
		end
		chars_if.ready <= next_ready;
	end

	// Watchdog on the whole run.
	always @(posedge clk) begin
		cycles++;
		if (cycles >= CYCLE_LIMIT) begin
			$display("integer_to_radix_digits_core: mismatch");
			$finish;
		end
	end

	initial begin : run
		logic [itrd_pkg::RADIX_W-1:0]    radix;
		logic [itrd_pkg::CFG_DATA_W-1:0] word;
		logic [itrd_pkg::CFG_DATA_W-1:0] low_word;
		logic [itrd_pkg::CFG_DATA_W-1:0] high_word;
		arst_n          = 1'b0;
		cfg_we          = 1'b0;
		cfg_index       = itrd_pkg::REG_BASE_SIZE;
		cfg_data        = '0;
		values_if.valid = 1'b0;
		values_if.value = '0;
		chars_if.ready  = 1'b0;
		radix_setting   = itrd_pkg::BASE_SIZE_RST;
		glyphs_low      = itrd_pkg::CHARS_LOW_RST;
		glyphs_high     = itrd_pkg::CHARS_HIGH_RST;
		repeat (RESET_CYCLES) @(negedge clk);
		arst_n <= 1'b1;
		bursts_on = 1'b1;

		// Corner values under the settings left by reset: zero, one, minus
		// one, both extremes, and numbers with many and few digits.
		foreach (DIRECTED_NUMBERS[i])
			numbers_to_send.push_back(DIRECTED_NUMBERS[i]);
		wait_idle();

		// A radix of zero or one drops every number.
		write_reg(itrd_pkg::REG_BASE_SIZE, 64'd0);
		numbers_to_send.push_back(32'd7);
		numbers_to_send.push_back(32'hFFFF_FFF9);
		wait_idle();
		write_reg(itrd_pkg::REG_BASE_SIZE, 64'd1);
		numbers_to_send.push_back(32'd0);
		numbers_to_send.push_back(32'd12345);
		wait_idle();

		// A plus sign in the last alphabet entry blocks radix sixteen but
		// not radix fifteen, where that entry is out of use.
		write_reg(itrd_pkg::REG_CHARS_HIGH,
		          {itrd_pkg::CHAR_PLUS, itrd_pkg::CHARS_HIGH_RST[55:0]});
		write_reg(itrd_pkg::REG_BASE_SIZE, 64'd16);
		numbers_to_send.push_back(32'd255);
		numbers_to_send.push_back(32'hFFFF_FFFF);
		wait_idle();
		write_reg(itrd_pkg::REG_BASE_SIZE, 64'd15);
		numbers_to_send.push_back(32'd255);
		numbers_to_send.push_back(32'hFFFF_FFFF);
		wait_idle();

		// A minus sign as the first digit character blocks any radix.
		write_reg(itrd_pkg::REG_CHARS_LOW,
		          {itrd_pkg::CHARS_LOW_RST[63:8], itrd_pkg::CHAR_MINUS});
		write_reg(itrd_pkg::REG_BASE_SIZE, 64'd2);
		numbers_to_send.push_back(32'd5);
		wait_idle();

		// NUL bytes and repeated characters are ordinary digits.
		write_reg(itrd_pkg::REG_CHARS_LOW, 64'd0);
		write_reg(itrd_pkg::REG_CHARS_HIGH, {8{8'h41}});
		write_reg(itrd_pkg::REG_BASE_SIZE, 64'd16);
		numbers_to_send.push_back(32'h0F0F_00F0);
		wait_idle();

		// A write to the unused index changes nothing, and only the low
		// bits of the radix register count: this one reads as seventeen,
		// which is taken as sixteen.
		write_reg(REG_UNUSED, {$urandom, $urandom});
		write_reg(itrd_pkg::REG_BASE_SIZE, 64'hFFFF_FFFF_FFFF_FFF1);
		numbers_to_send.push_back(32'h8000_0000);
		wait_idle();

		// Random phases: each programs a radix and a sign-free alphabet,
		// then sends a batch of random numbers. The first phases pin the
		// smallest radix, the largest, one that saturates, and an odd one.
		for (int phase = 0; phase < RANDOM_PHASES; phase++) begin
			case (phase)
				0: radix = 5'd2;
				1: radix = 5'd16;
				2: radix = 5'd31;
				3: radix = 5'd3;
				default: radix = itrd_pkg::RADIX_W'($urandom_range(2, 31));
			endcase
			word = {$urandom, $urandom};
			word[itrd_pkg::RADIX_W-1:0] = radix;
			low_word  = {$urandom, $urandom};
			high_word = {$urandom, $urandom};
			for (int b = 0; b < 8; b++) begin
				if (low_word[8*b +: 8] == itrd_pkg::CHAR_PLUS ||
				    low_word[8*b +: 8] == itrd_pkg::CHAR_MINUS)
					low_word[8*b +: 8] ^= 8'h80;
				if (high_word[8*b +: 8] == itrd_pkg::CHAR_PLUS ||
				    high_word[8*b +: 8] == itrd_pkg::CHAR_MINUS)
					high_word[8*b +: 8] ^= 8'h80;
			end
			write_reg(itrd_pkg::REG_CHARS_LOW, low_word);
			write_reg(itrd_pkg::REG_CHARS_HIGH, high_word);
			write_reg(itrd_pkg::REG_BASE_SIZE, word);
			// Part way through, the receiver stops for a long time while
			// numbers keep coming, so the input channel has to back off.
			if (phase == 6)
				hold_requests++;
			repeat (PHASE_ITEMS) numbers_to_send.push_back(random_number());
			wait_idle();
		end

		// Closing phase at full rate on both sides, back on the reset
		// radix and alphabet.
		bursts_on = 1'b0;
		write_reg(itrd_pkg::REG_CHARS_LOW, itrd_pkg::CHARS_LOW_RST);
		write_reg(itrd_pkg::REG_CHARS_HIGH, itrd_pkg::CHARS_HIGH_RST);
		write_reg(itrd_pkg::REG_BASE_SIZE, 64'(itrd_pkg::BASE_SIZE_RST));
		repeat (PHASE_ITEMS) numbers_to_send.push_back(random_number());
		wait_idle();

		if (errors == 0)
			$display("integer_to_radix_digits_core: match");
		else
			$display("integer_to_radix_digits_core: mismatch");
		$finish;
	end

endmodule
